// ----- rtl/core/lslm_pkg.sv -----
`timescale 1ns / 1ps

package lslm_pkg;

  // Number of axes that carry a min and a max switch.
  localparam int SWITCH_AXES = 4;
  localparam int SWITCHES    = 2 * SWITCH_AXES;

  localparam logic [7:0] RESET_LOCKOUT = 8'd10;

  typedef logic [2:0] func_t;
  typedef logic [2:0] mode_t;
  typedef logic [2:0] cfg_index_t;

  // Event kinds.
  localparam func_t FUNC_EDGE    = 3'd0;
  localparam func_t FUNC_TICK    = 3'd1;
  localparam func_t FUNC_SAMPLE  = 3'd2;
  localparam func_t FUNC_DIAG    = 3'd3;
  localparam func_t FUNC_SERVICE = 3'd4;

  // Switch modes.
  localparam mode_t MODE_DISABLED   = 3'd0;
  localparam mode_t MODE_HOMING_NO  = 3'd1;
  localparam mode_t MODE_HOMING_NC  = 3'd2;
  localparam mode_t MODE_ENABLED_NO = 3'd3;
  localparam mode_t MODE_ENABLED_NC = 3'd4;

  // Configuration register indexes.
  localparam cfg_index_t REG_MODE_X  = 3'd0;
  localparam cfg_index_t REG_MODE_Y  = 3'd1;
  localparam cfg_index_t REG_MODE_Z  = 3'd2;
  localparam cfg_index_t REG_MODE_A  = 3'd3;
  localparam cfg_index_t REG_LOCKOUT = 3'd4;

  typedef struct packed {
    logic [7:0] lockout;
    logic [7:0] flags;
    logic       thrown;
  } state_t;

  typedef struct packed {
    logic feedhold_req;
    logic abort_req;
    logic service_status;
  } pulse_t;

endpackage

// ----- rtl/core/lslm_ifs.sv -----
`timescale 1ns / 1ps

interface lslm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] switch_index;
  logic [7:0] pin_levels;
  logic       homing_cycle;

  modport source (output valid, func, switch_index, pin_levels, homing_cycle, input ready);
  modport sink (input valid, func, switch_index, pin_levels, homing_cycle, output ready);
endinterface

interface lslm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] switch_flags;
  logic       thrown;
  logic       feedhold_req;
  logic       abort_req;
  logic       service_status;

  modport source (output valid, switch_flags, thrown, feedhold_req, abort_req,
                  service_status, input ready);
  modport sink (input valid, switch_flags, thrown, feedhold_req, abort_req,
                service_status, output ready);
endinterface

// ----- rtl/core/lslm_step.sv -----
`timescale 1ns / 1ps

module lslm_step #(
  parameter int ACTIVE_AXES = 4
) (
  input  lslm_pkg::state_t cur,
  input  lslm_pkg::mode_t  modes [lslm_pkg::SWITCH_AXES],
  input  logic [7:0]       lockout_ticks,
  input  lslm_pkg::func_t  func,
  input  logic [2:0]       switch_index,
  input  logic [7:0]       pin_levels,
  input  logic             homing_cycle,
  output lslm_pkg::state_t nxt,
  output lslm_pkg::pulse_t pulses
);

  // In a pin sample, switches on axes beyond the active count never read as closed.
  localparam logic [lslm_pkg::SWITCH_AXES-1:0] HALF_MASK =
    lslm_pkg::SWITCH_AXES'((1 << ACTIVE_AXES) - 1);
  localparam logic [lslm_pkg::SWITCHES-1:0] SAMPLE_MASK = {HALF_MASK, HALF_MASK};

  logic [1:0]            axis;
  lslm_pkg::mode_t       mode;
  logic [7:0]            sw_bit;
  logic [7:0]            sampled;
  logic                  enabled;

  assign axis    = switch_index[1:0];
  assign mode    = modes[axis];
  assign sw_bit  = 8'd1 << switch_index;
  assign sampled = ~pin_levels & SAMPLE_MASK;
  assign enabled = (mode == lslm_pkg::MODE_ENABLED_NO) ||
                   (mode == lslm_pkg::MODE_ENABLED_NC);

  always_comb begin
    nxt    = cur;
    pulses = '0;
    unique case (func)
      lslm_pkg::FUNC_EDGE: begin
        // Axes that are not fitted read as disabled, so their edges drop here.
        if (cur.lockout == 8'd0 && mode != lslm_pkg::MODE_DISABLED) begin
          nxt.thrown          = 1'b1;
          nxt.flags           = cur.flags | sw_bit;
          nxt.lockout         = lockout_ticks;
          pulses.feedhold_req = homing_cycle;
          pulses.abort_req    = !homing_cycle && enabled;
        end
      end
      lslm_pkg::FUNC_TICK: begin
        if (cur.lockout != 8'd0) begin
          nxt.lockout = cur.lockout - 8'd1;
        end
      end
      lslm_pkg::FUNC_SAMPLE: begin
        nxt.flags  = sampled;
        nxt.thrown = |sampled;
      end
      lslm_pkg::FUNC_DIAG: begin
        nxt.thrown = 1'b1;
        nxt.flags  = cur.flags | sw_bit;
      end
      lslm_pkg::FUNC_SERVICE: begin
        if (cur.thrown) begin
          pulses.service_status = 1'b1;
          nxt.thrown            = 1'b0;
          nxt.flags             = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/limit_switch_lockout_monitor_core.sv -----
`timescale 1ns / 1ps

// Limit and homing switch monitor for up to four axes, each with a min and a
// max switch. Every transaction on in_ch is one event (switch edge, lockout
// tick, pin sample, diagnostic set or service) and yields exactly one
// transaction on out_ch carrying the flag vector and thrown mark after the
// event, plus the feedhold, abort and service pulses that the event raised.
// Switch modes and the lockout length are written through the cfg_* port,
// one register per cycle; the user must write them only while no event is
// in flight, as the block does not enforce it. An accepted event's result
// is registered and offered on out_ch in the next cycle. Throughput is one
// event per cycle while the receiver takes each result, set by the single
// update stage between the state registers and the result register.
// in_ch.ready stays high while the result register is empty or being taken
// in the same cycle; on a stall the result is held and further events are
// refused until it is taken. Synchronous reset clears the flags, the thrown
// mark and the lockout count, sets all axes to disabled and the lockout
// length to ten ticks, and empties the result register.
module limit_switch_lockout_monitor_core #(
  parameter int AXES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  lslm_in_if.sink              in_ch,
  lslm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  lslm_pkg::cfg_index_t cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int ACTIVE_AXES = (AXES > lslm_pkg::SWITCH_AXES) ? lslm_pkg::SWITCH_AXES : AXES;

  lslm_pkg::mode_t  modes [lslm_pkg::SWITCH_AXES];
  logic [7:0]       lockout_ticks;
  lslm_pkg::state_t state;
  lslm_pkg::state_t state_next;
  lslm_pkg::pulse_t pulses;
  logic             accept;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Axes that are not fitted keep their mode at disabled.
  always_ff @(posedge clk) begin
    for (int i = 0; i < lslm_pkg::SWITCH_AXES; i++) begin
      if (rst || i >= ACTIVE_AXES) begin
        modes[i] <= lslm_pkg::MODE_DISABLED;
      end else if (cfg_we && cfg_index == lslm_pkg::cfg_index_t'(i)) begin
        modes[i] <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= lslm_pkg::RESET_LOCKOUT;
    end else if (cfg_we && cfg_index == lslm_pkg::REG_LOCKOUT) begin
      lockout_ticks <= cfg_data;
    end
  end

  lslm_step #(
    .ACTIVE_AXES (ACTIVE_AXES)
  ) u_step (
    .cur           (state),
    .modes         (modes),
    .lockout_ticks (lockout_ticks),
    .func          (in_ch.func),
    .switch_index  (in_ch.switch_index),
    .pin_levels    (in_ch.pin_levels),
    .homing_cycle  (in_ch.homing_cycle),
    .nxt           (state_next),
    .pulses        (pulses)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Result payload carries no reset; it is qualified by out_ch.valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.switch_flags   <= state_next.flags;
      out_ch.thrown         <= state_next.thrown;
      out_ch.feedhold_req   <= pulses.feedhold_req;
      out_ch.abort_req      <= pulses.abort_req;
      out_ch.service_status <= pulses.service_status;
    end
  end

  // The offered result always mirrors the state it was taken from.
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.switch_flags == state.flags && out_ch.thrown == state.thrown))
    else $error("result does not match the monitor state");

  a_tick_counts_down: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.func == lslm_pkg::FUNC_TICK && state.lockout != 8'd0)
    |=> state.lockout == $past(state.lockout) - 8'd1)
    else $error("lockout tick did not count down by one");

  a_edge_in_lockout_ignored: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.func == lslm_pkg::FUNC_EDGE && state.lockout != 8'd0)
    |=> (state == $past(state) && !out_ch.feedhold_req && !out_ch.abort_req))
    else $error("switch edge during lockout changed the state");

  a_service_clears: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.service_status)
    |-> (out_ch.switch_flags == 8'd0 && !out_ch.thrown && !out_ch.feedhold_req))
    else $error("service reported thrown but did not clear the flags");

endmodule

// ----- dv/limit_switch_lockout_monitor_core_tb.sv -----
`timescale 1ns / 1ps

module limit_switch_lockout_monitor_core_tb;

  localparam int AXES = 4;
  localparam int ACTIVE_AXES = (AXES > lslm_pkg::SWITCH_AXES) ? lslm_pkg::SWITCH_AXES : AXES;
  localparam int RUN_LIMIT_NS = 2000000;

  typedef struct packed {
    lslm_pkg::func_t func;
    logic [2:0]      switch_index;
    logic [7:0]      pin_levels;
    logic            homing_cycle;
  } switch_event_t;

  typedef struct packed {
    logic [7:0] switch_flags;
    logic       thrown;
    logic       feedhold_req;
    logic       abort_req;
    logic       service_status;
  } switch_report_t;

  logic clk;
  logic rst;
  logic cfg_we;
  lslm_pkg::cfg_index_t cfg_index;
  logic [7:0] cfg_data;

  lslm_in_if  in_ch ();
  lslm_out_if out_ch ();

  limit_switch_lockout_monitor_core #(
    .AXES(AXES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the configuration registers and of the monitor state.
  lslm_pkg::mode_t axis_mode [lslm_pkg::SWITCH_AXES];
  logic [7:0]      lockout_len;
  logic [7:0]      lockout_count;
  logic [7:0]      flag_bits;
  logic            thrown_mark;

  switch_event_t  pending_events [$];
  switch_report_t expected_reports [$];
  switch_event_t  offered_event;
  int             fail_count;

  always #1 clk = ~clk;

  function automatic switch_report_t predict_switch_event(input switch_event_t ev);
    switch_report_t  r;
    logic [1:0]      axis;
    lslm_pkg::mode_t m;
    logic [7:0]      active_mask;
    r = '0;
    axis = ev.switch_index[1:0];
    active_mask = '0;
    for (int i = 0; i < ACTIVE_AXES; i++) begin
      active_mask[i] = 1'b1;
      active_mask[i + lslm_pkg::SWITCH_AXES] = 1'b1;
    end
    case (ev.func)
      lslm_pkg::FUNC_EDGE: begin
        if (lockout_count == 8'd0 && int'(axis) < ACTIVE_AXES) begin
          m = axis_mode[axis];
          if (m != lslm_pkg::MODE_DISABLED) begin
            thrown_mark = 1'b1;
            flag_bits[ev.switch_index] = 1'b1;
            lockout_count = lockout_len;
            if (ev.homing_cycle)
              r.feedhold_req = 1'b1;
            else if (m == lslm_pkg::MODE_ENABLED_NO || m == lslm_pkg::MODE_ENABLED_NC)
              r.abort_req = 1'b1;
          end
        end
      end
      lslm_pkg::FUNC_TICK: begin
        if (lockout_count != 8'd0)
          lockout_count = lockout_count - 8'd1;
      end
      lslm_pkg::FUNC_SAMPLE: begin
        flag_bits = ~ev.pin_levels & active_mask;
        thrown_mark = |flag_bits;
      end
      lslm_pkg::FUNC_DIAG: begin
        thrown_mark = 1'b1;
        flag_bits[ev.switch_index] = 1'b1;
      end
      lslm_pkg::FUNC_SERVICE: begin
        if (thrown_mark) begin
          r.service_status = 1'b1;
          thrown_mark = 1'b0;
          flag_bits = '0;
        end
      end
      default: ;
    endcase
    r.switch_flags = flag_bits;
    r.thrown = thrown_mark;
    return r;
  endfunction

  // Sender: bursts of back-to-back transactions separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_reports.push_back(predict_switch_event(offered_event));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          offered_event = pending_events.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= offered_event.func;
          in_ch.switch_index <= offered_event.switch_index;
          in_ch.pin_levels <= offered_event.pin_levels;
          in_ch.homing_cycle <= offered_event.homing_cycle;
          if (burst_left == 0)
            burst_left = int'($urandom_range(1, 30));
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transaction and stalls on a rotating pattern,
  // with two long hold-offs so that the block backs up into its input.
  logic [31:0] stall_pattern;
  logic [4:0]  stall_phase;
  int          hold_left;
  int          reports_seen;
  switch_report_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_phase = '0;
      stall_pattern = '1;
      hold_left = 0;
      reports_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (reports_seen == 500 || reports_seen == 1400)
          hold_left = 120;
        if (expected_reports.size() == 0) begin
          $error("result arrived with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.switch_flags !== want.switch_flags) begin
            $error("switch_flags: expected %h, got %h", want.switch_flags, out_ch.switch_flags);
            fail_count++;
          end
          if (out_ch.thrown !== want.thrown) begin
            $error("thrown: expected %b, got %b", want.thrown, out_ch.thrown);
            fail_count++;
          end
          if (out_ch.feedhold_req !== want.feedhold_req) begin
            $error("feedhold_req: expected %b, got %b", want.feedhold_req,
                   out_ch.feedhold_req);
            fail_count++;
          end
          if (out_ch.abort_req !== want.abort_req) begin
            $error("abort_req: expected %b, got %b", want.abort_req, out_ch.abort_req);
            fail_count++;
          end
          if (out_ch.service_status !== want.service_status) begin
            $error("service_status: expected %b, got %b", want.service_status,
                   out_ch.service_status);
            fail_count++;
          end
        end
      end
      if (stall_phase == 5'd0)
        stall_pattern = ($urandom_range(0, 2) == 0) ? '1 : $urandom;
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= stall_pattern[stall_phase];
      end
    end
  end

  task automatic queue_event(input lslm_pkg::func_t f, input logic [2:0] sw,
                             input logic [7:0] pins, input logic homing);
    switch_event_t ev;
    ev.func = f;
    ev.switch_index = sw;
    ev.pin_levels = pins;
    ev.homing_cycle = homing;
    pending_events.push_back(ev);
  endtask

  task automatic queue_noise(input lslm_pkg::func_t f);
    queue_event(f, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Sampled on the falling edge, once every update of the rising edge has settled.
  task automatic wait_until_idle();
    @(negedge clk);
    while (pending_events.size() != 0 || in_ch.valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input lslm_pkg::mode_t mx, input lslm_pkg::mode_t my,
                           input lslm_pkg::mode_t mz, input lslm_pkg::mode_t ma,
                           input logic [7:0] lockout);
    lslm_pkg::cfg_index_t idx [5];
    logic [7:0]           val [5];
    wait_until_idle();
    idx = '{lslm_pkg::REG_MODE_X, lslm_pkg::REG_MODE_Y, lslm_pkg::REG_MODE_Z,
            lslm_pkg::REG_MODE_A, lslm_pkg::REG_LOCKOUT};
    val = '{8'(mx), 8'(my), 8'(mz), 8'(ma), lockout};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      if (idx[i] == lslm_pkg::REG_LOCKOUT)
        lockout_len = val[i];
      else
        axis_mode[i] = val[i][2:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic lslm_pkg::mode_t pick_mode();
    return ($urandom_range(0, 4) == 0) ? lslm_pkg::mode_t'($urandom_range(5, 7))
                                       : lslm_pkg::mode_t'($urandom_range(0, 4));
  endfunction

  // Mostly an edge followed by a run of ticks that at least half the time clears
  // the lockout, so that later edges are taken; the rest is unstructured noise.
  task automatic queue_random_events(input int count);
    int added;
    int ticks;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_noise(lslm_pkg::FUNC_EDGE);
        ticks = $urandom_range(0, 1) ? int'(lockout_len)
                                     : int'($urandom_range(0, int'(lockout_len) + 1));
        repeat (ticks) queue_noise(lslm_pkg::FUNC_TICK);
        added += ticks + 1;
        case ($urandom_range(0, 3))
          0: queue_noise(lslm_pkg::FUNC_SERVICE);
          1: queue_noise(lslm_pkg::FUNC_SAMPLE);
          2: queue_noise(lslm_pkg::FUNC_DIAG);
          default: ;
        endcase
        added++;
      end else begin
        queue_noise(lslm_pkg::func_t'($urandom_range(0, 7)));
        added++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = lslm_pkg::REG_MODE_X;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = lslm_pkg::FUNC_TICK;
    in_ch.switch_index = '0;
    in_ch.pin_levels = '0;
    in_ch.homing_cycle = 1'b0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    for (int i = 0; i < lslm_pkg::SWITCH_AXES; i++)
      axis_mode[i] = lslm_pkg::MODE_DISABLED;
    lockout_len = lslm_pkg::RESET_LOCKOUT;
    lockout_count = '0;
    flag_bits = '0;
    thrown_mark = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every axis disabled, so edges are ignored.
    queue_event(lslm_pkg::FUNC_EDGE, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_DIAG, 3'd7, 8'hFF, 1'b1);
    queue_event(lslm_pkg::FUNC_SERVICE, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_SERVICE, 3'd7, 8'hFF, 1'b1);
    queue_event(lslm_pkg::FUNC_SAMPLE, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_SAMPLE, 3'd0, 8'hFF, 1'b0);
    queue_event(lslm_pkg::FUNC_TICK, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::func_t'(5), 3'd1, 8'h5A, 1'b0);
    queue_event(lslm_pkg::func_t'(6), 3'd2, 8'hA5, 1'b1);
    queue_event(lslm_pkg::func_t'(7), 3'd3, 8'h00, 1'b0);

    // One axis in each homing and enabled mode, with no lockout at all.
    configure(lslm_pkg::MODE_HOMING_NO, lslm_pkg::MODE_HOMING_NC, lslm_pkg::MODE_ENABLED_NO,
              lslm_pkg::MODE_ENABLED_NC, 8'd0);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd0, 8'h00, 1'b1);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd4, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd2, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd7, 8'h00, 1'b1);
    queue_event(lslm_pkg::FUNC_SERVICE, 3'd0, 8'h00, 1'b0);

    // Undefined mode codes and a short lockout.
    configure(lslm_pkg::mode_t'(5), lslm_pkg::mode_t'(6), lslm_pkg::mode_t'(7),
              lslm_pkg::MODE_DISABLED, 8'd2);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd1, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd0, 8'h00, 1'b1);
    queue_event(lslm_pkg::FUNC_DIAG, 3'd3, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_TICK, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_TICK, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_TICK, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd6, 8'h00, 1'b1);
    queue_event(lslm_pkg::FUNC_TICK, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_TICK, 3'd0, 8'h00, 1'b0);
    queue_event(lslm_pkg::FUNC_EDGE, 3'd3, 8'h00, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(), 8'd1);
        1: configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(), 8'd255);
        2: configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(),
                     8'($urandom_range(2, 12)));
        3: configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(), 8'd0);
        4: configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(),
                     8'($urandom_range(0, 255)));
        default: configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(), 8'd3);
      endcase
      queue_random_events(310);
    end

    wait_until_idle();
    repeat (3) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
